// ----- src/smmwa_pkg.sv -----
// ----------------------------------------------------------------------------
// smmwa_pkg
// Shared types and constants for the sample min/max window averager.
// ----------------------------------------------------------------------------
`default_nettype none

package smmwa_pkg;

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 56;
  localparam int unsigned LevelW    = 12;
  localparam int unsigned AvgW      = 16;
  localparam int unsigned FracBits  = 4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- src/smmwa_cell.sv -----
// ----------------------------------------------------------------------------
// smmwa_cell
// One window cell: holds a sample and passes it to its neighbor on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module smmwa_cell #(
  parameter int unsigned W = 12
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         shift_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

`default_nettype wire

// ----- src/smmwa_div.sv -----
// ----------------------------------------------------------------------------
// smmwa_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smmwa_div
  import smmwa_pkg::*;
#(
  parameter int unsigned DVD_W = 20,
  parameter int unsigned DVS_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output div_stat_t             stat_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int unsigned ItW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [ItW-1:0]   iter_q, iter_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    busy_d  = busy_q;
    done_d  = done_q;
    iter_d  = iter_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      iter_d = ItW'(DVD_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], fits};
      rem_d = fits ? DVS_W'(rem_sub) : DVS_W'(rem_sh);
      if (iter_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        iter_d = iter_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire

// ----- src/sample_min_max_window_average.sv -----
// ----------------------------------------------------------------------------
// sample_min_max_window_average
// Sliding window average of converter samples with min/max tracking.
// ----------------------------------------------------------------------------
// The slave channel takes one sample per beat. The master channel returns one
// beat per sample with the sample, the lowest and highest sample since reset
// and the window average in counts with four fraction bits.
// The window is a row of cells that shift on every accepted sample; the cell
// falling off the end is subtracted from the running sum.
// The average comes from a restoring divider with one quotient bit per cycle.
// The result beat is loaded into the output register once the divider is done
// and the register is free, and the next sample is taken only after that load,
// so the block takes no new sample while the previous one is still in work.
// A new sample is accepted once the previous result has left the divider, even
// while the output register still waits for the receiver. When the receiver
// stalls, the output beat holds and the finished quotient waits in the
// divider. Reset clears the window, sum, count, min and max and both valids.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_min_max_window_average
  import smmwa_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // Fields from bit 0: sample[11:0], zero padding.
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // Fields from bit 0: echo_sample[11:0], low_level[11:0], high_level[11:0],
  // average_x16[15:0], zero padding.
  output logic [OutTdataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned CntW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW  = LevelW + $clog2(WINDOW_DEPTH);
  localparam int unsigned DvdW  = SumW + FracBits;

  logic [LevelW-1:0]      chain [WINDOW_DEPTH+1];
  logic [LevelW-1:0]      sample;
  logic                   in_fire;
  logic                   out_load;

  logic [SumW-1:0]        sum_q, sum_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [LevelW-1:0]      min_q, min_d;
  logic [LevelW-1:0]      max_q, max_d;
  logic                   pending_q, pending_d;
  logic                   out_valid_q, out_valid_d;
  logic [OutTdataW-1:0]   out_data_q, out_data_d;

  div_stat_t              div_stat;
  logic [DvdW-1:0]        quotient;

  assign sample          = s_axis_tdata_i[LevelW-1:0];
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !pending_q;
  assign chain[0]        = sample;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    smmwa_cell #(
      .W(LevelW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(in_fire),
      .d_i    (chain[i]),
      .q_o    (chain[i+1])
    );
  end

  assign sum_d = sum_q - SumW'(chain[WINDOW_DEPTH]) + SumW'(sample);
  assign cnt_d = (cnt_q < CntW'(WINDOW_DEPTH)) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (cnt_q == '0) begin
      min_d = sample;
      max_d = sample;
    end else begin
      if (sample < min_q) begin
        min_d = sample;
      end
      if (sample > max_q) begin
        max_d = sample;
      end
    end
  end

  smmwa_div #(
    .DVD_W(DvdW),
    .DVS_W(CntW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_fire),
    .dividend_i({sum_d, FracBits'(0)}),
    .divisor_i (cnt_d),
    .stat_o    (div_stat),
    .quotient_o(quotient)
  );

  assign out_load  = pending_q && div_stat.done && (!out_valid_q || m_axis_tready_i);
  assign pending_d = in_fire ? 1'b1 : (out_load ? 1'b0 : pending_q);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = OutTdataW'({AvgW'(quotient), LevelW'(max_q), LevelW'(min_q),
                                LevelW'(chain[1])});
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
        min_q <= min_d;
        max_q <= max_d;
      end
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

// ----- src/smmwa_checker.sv -----
// ----------------------------------------------------------------------------
// smmwa_checker
// Port-level assertions for the sample min/max window averager.
// ----------------------------------------------------------------------------
`default_nettype none

module smmwa_checker
  import smmwa_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid_i,
  input wire logic                 s_axis_tready_o,
  input wire logic                 m_axis_tvalid_o,
  input wire logic                 m_axis_tready_i,
  input wire logic [OutTdataW-1:0] m_axis_tdata_o
);

  logic [LevelW-1:0] echo;
  logic [LevelW-1:0] low;
  logic [LevelW-1:0] high;
  logic [AvgW-1:0]   avg;

  assign echo = m_axis_tdata_o[11:0];
  assign low  = m_axis_tdata_o[23:12];
  assign high = m_axis_tdata_o[35:24];
  assign avg  = m_axis_tdata_o[51:36];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled output beat changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("Input accepted while a sample was still in work.");

  a_echo_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> low <= echo && echo <= high)
    else $error("Sample lies outside the reported min/max range.");

  a_avg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> avg >= {low, 4'b0000} && avg <= {high, 4'b0000})
    else $error("Average lies outside the reported min/max range.");

endmodule

bind sample_min_max_window_average smmwa_checker u_smmwa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire
